// ----- sv/izn_pkg.sv -----
// shared types, register indexes and saturation helper for the neuron core
package izn_pkg;

   // request payload: one simulation tick
   typedef struct packed {
      logic signed [31:0] synaptic_current;
      logic signed [31:0] noise_sample;
   } req_type;

   // response payload: one result per tick
   typedef struct packed {
      logic signed [31:0] membrane_potential;
      logic signed [31:0] recovery_value;
      logic               spiked;
      logic [30:0]        raw_output;
      logic [15:0]        normalized_output;
   } rsp_type;

   // configuration register file
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = 4;
   localparam int REG_W    = 3;

   localparam logic [REG_W-1:0] REG_K_GAIN      = 3'd0;
   localparam logic [REG_W-1:0] REG_REST_POT    = 3'd1;
   localparam logic [REG_W-1:0] REG_THRESH_POT  = 3'd2;
   localparam logic [REG_W-1:0] REG_PEAK_POT    = 3'd3;
   localparam logic [REG_W-1:0] REG_REC_RATE    = 3'd4;
   localparam logic [REG_W-1:0] REG_REC_SENS    = 3'd5;
   localparam logic [REG_W-1:0] REG_RESET_POT   = 3'd6;
   localparam logic [REG_W-1:0] REG_REC_JUMP    = 3'd7;

   localparam logic signed [31:0] CFG_RESET [NUM_REGS] = '{
      32'sd45875, -32'sd3932160, -32'sd2621440, 32'sd2293760,
      32'sd1966, -32'sd131072, -32'sd3276800, 32'sd6553600
   };

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/izhikevich_neuron_alpha_output_core.sv -----
// izhikevich neuron euler step with alpha-kernel spike output over a cell chain
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  izn_pkg::req_type
//   rsp       out        rsp_valid/rsp_ready  izn_pkg::rsp_type
//   csr       in         csr_we               csr_index, csr_wdata
//
// one request at a time: from accept to result it runs the euler states, then the sum wave
// through the 10*ALPHA_BASE+1 history cells and the 16-step divider
// the euler step runs five products through one shared 32x32 multiplier
// synchronous active-high reset; no clearing pass, history cells reset at once
// a waiting response holds in its output register while the next request is taken
module izhikevich_neuron_alpha_output_core #(
   parameter int ALPHA_BASE          = 8,
   parameter int INV_CAPACITANCE_Q16 = 655,
   parameter int BASELINE_CURRENT    = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  izn_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output izn_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [izn_pkg::IDX_W-1:0] csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int HIST_LEN = 10 * ALPHA_BASE + 1;
   localparam int CNT_W    = $clog2(HIST_LEN);
   localparam logic signed [31:0] INV_Q  = 32'(INV_CAPACITANCE_Q16);
   localparam logic signed [31:0] BASE_Q = 32'(BASELINE_CURRENT);

   // decay ratio exp(-1/ALPHA_BASE) in Q0.32, truncated taylor terms
   localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
   localparam logic [63:0] E_Q30   = 64'd2918732889;
   localparam logic [63:0] TERM_1  = ONE_Q32 / 64'(ALPHA_BASE);
   localparam logic [63:0] TERM_2  = TERM_1 / 64'(2 * ALPHA_BASE);
   localparam logic [63:0] TERM_3  = TERM_2 / 64'(3 * ALPHA_BASE);
   localparam logic [63:0] TERM_4  = TERM_3 / 64'(4 * ALPHA_BASE);
   localparam logic [63:0] TERM_5  = TERM_4 / 64'(5 * ALPHA_BASE);
   localparam logic [63:0] TERM_6  = TERM_5 / 64'(6 * ALPHA_BASE);
   localparam logic [63:0] TERM_7  = TERM_6 / 64'(7 * ALPHA_BASE);
   localparam logic [63:0] TERM_8  = TERM_7 / 64'(8 * ALPHA_BASE);
   localparam logic [63:0] TERM_9  = TERM_8 / 64'(9 * ALPHA_BASE);
   localparam logic [63:0] TERM_10 = TERM_9 / 64'(10 * ALPHA_BASE);
   localparam logic [63:0] TERM_11 = TERM_10 / 64'(11 * ALPHA_BASE);
   localparam logic [63:0] TERM_12 = TERM_11 / 64'(12 * ALPHA_BASE);
   localparam logic [63:0] DECAY_Q32 = ONE_Q32 - TERM_1 + TERM_2 - TERM_3 + TERM_4
                                     - TERM_5 + TERM_6 - TERM_7 + TERM_8 - TERM_9
                                     + TERM_10 - TERM_11 + TERM_12;
   localparam logic [63:0] KERNEL_DIV = 64'(ALPHA_BASE) << 14;

   // e * decay^n in Q2.30
   function automatic logic [63:0] kernel_w(input int n);
      logic [63:0] w;
      w = E_Q30;
      for (int i = 0; i < n; i++) begin
         w = (w * DECAY_Q32) >> 32;
      end
      return w;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_MP, ST_MQ, ST_MBD, ST_MSUM, ST_MSV, ST_MRU,
      ST_UPD, ST_SCAN, ST_DSTART, ST_DWAIT, ST_DONE
   } state_type;

   state_type          state_ff;
   logic signed [31:0] cfg_ff [izn_pkg::NUM_REGS];
   logic signed [31:0] vp_ff, u_ff, cur_ff, noi_ff;
   logic signed [31:0] d1_ff, d2_ff, q_ff, s_ff, t_ff, sv_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] res_v_ff, res_u_ff;
   logic               res_spk_ff;
   logic [30:0]        raw_ff;
   logic [15:0]        norm_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;
   izn_pkg::rsp_type   rsp_data_ff;

   logic signed [31:0] op_a, op_b, qm;
   logic signed [63:0] prod_in;
   logic signed [31:0] d1_in, d2_in, s_in, t_in, v_in, un0, un_in;
   logic               spk_in;
   logic               shift_en;
   logic               div_done;
   logic [15:0]        div_quot;
   logic               bit_chain [HIST_LEN+1];
   logic [30:0]        sum_chain [HIST_LEN+1];

   // shared multiplier operand select
   always_comb begin
      qm = izn_pkg::sat32(prod_ff >>> 16);
      case (state_ff)
         ST_MP: begin
            op_a = d1_ff;
            op_b = d2_ff;
         end
         ST_MQ: begin
            op_a = cfg_ff[izn_pkg::REG_K_GAIN];
            op_b = qm;
         end
         ST_MBD: begin
            op_a = cfg_ff[izn_pkg::REG_REC_SENS];
            op_b = d1_ff;
         end
         ST_MSV: begin
            op_a = s_ff;
            op_b = INV_Q;
         end
         ST_MRU: begin
            op_a = cfg_ff[izn_pkg::REG_REC_RATE];
            op_b = t_ff;
         end
         default: begin
            op_a = 32'sd0;
            op_b = 32'sd0;
         end
      endcase
      prod_in = 64'(op_a) * 64'(op_b);
   end

   // euler step arithmetic
   always_comb begin
      d1_in  = izn_pkg::sat32(64'(vp_ff) - 64'(cfg_ff[izn_pkg::REG_REST_POT]));
      d2_in  = izn_pkg::sat32(64'(vp_ff) - 64'(cfg_ff[izn_pkg::REG_THRESH_POT]));
      s_in   = izn_pkg::sat32(64'(q_ff) - 64'(u_ff) + 64'(BASE_Q)
                              + 64'(cur_ff) + 64'(noi_ff));
      t_in   = izn_pkg::sat32(64'(qm) - 64'(u_ff));
      v_in   = izn_pkg::sat32(64'(vp_ff) + 64'(sv_ff));
      un0    = izn_pkg::sat32(64'(u_ff) + 64'(qm));
      spk_in = v_in >= cfg_ff[izn_pkg::REG_PEAK_POT];
      un_in  = spk_in ? izn_pkg::sat32(64'(un0) + 64'(cfg_ff[izn_pkg::REG_REC_JUMP]))
                      : un0;
   end

   assign shift_en     = (state_ff == ST_UPD);
   assign bit_chain[0] = spk_in;
   assign sum_chain[0] = 31'd0;

   // history cell chain
   for (genvar g = 0; g < HIST_LEN; g++) begin : g_cell
      localparam logic [63:0] KERNEL_KV = (64'(g) * kernel_w(g)) / KERNEL_DIV;
      izn_cell #(.KVAL(KERNEL_KV[30:0])) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .bit_prev (bit_chain[g]),
         .bit_out  (bit_chain[g+1]),
         .sum_prev (sum_chain[g]),
         .sum_out  (sum_chain[g+1])
      );
   end

   izn_norm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DSTART),
      .raw   (sum_chain[HIST_LEN]),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer, neuron state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vp_ff        <= izn_pkg::CFG_RESET[izn_pkg::REG_RESET_POT];
         u_ff         <= izn_pkg::CFG_RESET[izn_pkg::REG_REC_JUMP];
         cnt_ff       <= '0;
         for (int i = 0; i < izn_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= izn_pkg::CFG_RESET[i];
         end
      end else begin
         if (csr_we && csr_index < izn_pkg::IDX_W'(izn_pkg::NUM_REGS)) begin
            cfg_ff[csr_index[izn_pkg::REG_W-1:0]] <= csr_wdata;
         end
         prod_ff <= prod_in;
         // response taken; ST_DONE refills the register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cur_ff   <= req_data.synaptic_current;
                  noi_ff   <= req_data.noise_sample;
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               d1_ff    <= d1_in;
               d2_ff    <= d2_in;
               state_ff <= ST_MP;
            end
            ST_MP:   state_ff <= ST_MQ;
            ST_MQ:   state_ff <= ST_MBD;
            ST_MBD: begin
               q_ff     <= qm;
               state_ff <= ST_MSUM;
            end
            ST_MSUM: begin
               s_ff     <= s_in;
               t_ff     <= t_in;
               state_ff <= ST_MSV;
            end
            ST_MSV:  state_ff <= ST_MRU;
            ST_MRU: begin
               sv_ff    <= qm;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               res_v_ff   <= v_in;
               res_u_ff   <= un_in;
               res_spk_ff <= spk_in;
               u_ff       <= un_in;
               vp_ff      <= spk_in ? cfg_ff[izn_pkg::REG_RESET_POT] : v_in;
               cnt_ff     <= '0;
               state_ff   <= ST_SCAN;
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(HIST_LEN - 1)) begin
                  state_ff <= ST_DSTART;
               end
            end
            ST_DSTART: begin
               raw_ff   <= sum_chain[HIST_LEN];
               state_ff <= ST_DWAIT;
            end
            ST_DWAIT: begin
               if (div_done) begin
                  norm_ff  <= div_quot;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.membrane_potential <= res_v_ff;
                  rsp_data_ff.recovery_value     <= res_u_ff;
                  rsp_data_ff.spiked             <= res_spk_ff;
                  rsp_data_ff.raw_output         <= raw_ff;
                  rsp_data_ff.normalized_output  <= norm_ff;
                  rsp_valid_ff                   <= 1'b1;
                  state_ff                       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/izn_cell.sv -----
// one spike history cell: holds one age bit and adds its kernel weight to the passing sum
module izn_cell #(
   parameter logic [30:0] KVAL = 31'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        shift_en,
   input  logic        bit_prev,
   output logic        bit_out,
   input  logic [30:0] sum_prev,
   output logic [30:0] sum_out
);

   logic        bit_ff;
   logic [30:0] sum_ff;
   logic [31:0] sum_wide;
   logic [30:0] sum_in;

   // saturating add of this age's weight
   always_comb begin
      sum_wide = {1'b0, sum_prev} + (bit_ff ? {1'b0, KVAL} : 32'd0);
      sum_in   = sum_wide[31] ? 31'h7fffffff : sum_wide[30:0];
   end

   // history bit moves one age per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else if (shift_en) begin
         bit_ff <= bit_prev;
      end
   end

   // partial sum wave
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign bit_out = bit_ff;
   assign sum_out = sum_ff;

endmodule

// ----- sv/izn_norm_div.sv -----
// restoring divider for raw*65536 / (65536 + raw), one quotient bit per cycle
module izn_norm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] raw,
   output logic        done,
   output logic [15:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [31:0] den_ff;
   logic [15:0] q_ff;
   logic [32:0] rem2;
   logic        ge;
   logic [31:0] rem_in;

   // one shift and trial subtract
   always_comb begin
      rem2   = {rem_ff, 1'b0};
      ge     = rem2 >= {1'b0, den_ff};
      rem_in = ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, raw};
         den_ff <= 32'd65536 + {1'b0, raw};
         q_ff   <= 16'd0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[14:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- sv/izn_checker.sv -----
// port-level checks for the neuron core, bound to the top level
module izn_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input izn_pkg::rsp_type rsp_data
);

   // a waiting response is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before accept");

   // a taken request keeps the core busy next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no spike history gives a zero normalized output
   a_norm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.raw_output == 31'd0 |-> rsp_data.normalized_output == 16'd0)
      else $error("normalized output nonzero for zero raw");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind izhikevich_neuron_alpha_output_core izn_checker u_izn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/tb_izhikevich_neuron_alpha_output_core.sv -----
// testbench for the izhikevich neuron core with alpha-kernel spike output
`timescale 1ns / 100ps

module tb_izhikevich_neuron_alpha_output_core;

   localparam int ALPHA     = 8;
   localparam int INV_CAP   = 655;
   localparam int BASE_CUR  = 0;
   localparam int WIN_LEN   = 10 * ALPHA + 1;
   localparam int SETTLE    = 150;
   localparam int WD_LIMIT  = 6000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   izn_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   izn_pkg::rsp_type          rsp_data;
   logic                      csr_we;
   logic [izn_pkg::IDX_W-1:0] csr_index;
   logic [31:0]               csr_wdata;

   izhikevich_neuron_alpha_output_core #(
      .ALPHA_BASE(ALPHA), .INV_CAPACITANCE_Q16(INV_CAP), .BASELINE_CURRENT(BASE_CUR)
   ) dut (.*);

   // neuron state mirrored by the bench
   longint                 cfg [izn_pkg::NUM_REGS];
   longint                 mem_pot;
   longint                 rec_st;
   bit                     spike_win [WIN_LEN];
   longint unsigned        alpha_rom [WIN_LEN];

   izn_pkg::req_type  tick_q [$];
   izn_pkg::rsp_type  tick_expect_q [$];
   int       req_issued;
   int       req_accepts;
   int       fail_count;
   int       send_idle_pct;
   int       rsp_stall_pct;
   int       quiet_cycles;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint clamp32(longint x);
      longint r;
      r = x;
      if (x > 64'sd2147483647) r = 64'sd2147483647;
      if (x < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   function automatic longint qprod(longint a, longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> 16);
   endfunction

   // alpha kernel table built with integer arithmetic
   task automatic build_alpha_rom();
      longint unsigned term, ratio, w;
      term  = 64'd1 << 32;
      ratio = 64'd1 << 32;
      w     = 64'd2918732889;
      for (int j = 1; j <= 12; j++) begin
         term = term / (ALPHA * j);
         if (j % 2 == 1) ratio = ratio - term;
         else ratio = ratio + term;
      end
      for (int n = 0; n < WIN_LEN; n++) begin
         alpha_rom[n] = (longint'(n) * w) / (longint'(ALPHA) << 14);
         w = (w * ratio) >> 32;
      end
   endtask

   // one euler tick plus kernel sum, updates mirrored state
   function automatic izn_pkg::rsp_type neuron_tick(izn_pkg::req_type rq);
      izn_pkg::rsp_type r;
      longint          d1, d2, p, q, s, v, un;
      longint unsigned raw;
      bit              spk;
      d1 = clamp32(mem_pot - cfg[izn_pkg::REG_REST_POT]);
      d2 = clamp32(mem_pot - cfg[izn_pkg::REG_THRESH_POT]);
      p  = qprod(d1, d2);
      q  = qprod(cfg[izn_pkg::REG_K_GAIN], p);
      s  = clamp32(q - rec_st + BASE_CUR + longint'(rq.synaptic_current)
                   + longint'(rq.noise_sample));
      v  = clamp32(mem_pot + qprod(s, INV_CAP));
      un = clamp32(rec_st + qprod(cfg[izn_pkg::REG_REC_RATE],
                                  clamp32(qprod(cfg[izn_pkg::REG_REC_SENS], d1) - rec_st)));
      spk = (v >= cfg[izn_pkg::REG_PEAK_POT]);
      if (spk) begin
         mem_pot = cfg[izn_pkg::REG_RESET_POT];
         un = clamp32(un + cfg[izn_pkg::REG_REC_JUMP]);
      end else begin
         mem_pot = v;
      end
      rec_st = un;
      for (int n = WIN_LEN - 1; n > 0; n--) spike_win[n] = spike_win[n-1];
      spike_win[0] = spk;
      raw = 0;
      for (int n = 0; n < WIN_LEN; n++) begin
         if (spike_win[n]) begin
            raw = raw + alpha_rom[n];
            if (raw > 64'h7fffffff) raw = 64'h7fffffff;
         end
      end
      r.membrane_potential = v[31:0];
      r.recovery_value     = un[31:0];
      r.spiked             = spk;
      r.raw_output         = raw[30:0];
      r.normalized_output  = 16'((raw << 16) / (64'd65536 + raw));
      return r;
   endfunction

   // request driver, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_accepts != req_issued) begin
         req_valid <= 1'b1;
      end else if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid  <= 1'b1;
         req_data   <= tick_q.pop_front();
         req_issued <= req_issued + 1;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      izn_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            tick_expect_q.insert(tick_expect_q.size(), neuron_tick(req_data));
            req_accepts <= req_accepts + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (tick_expect_q.size() == 0) begin
               $error("response with no request pending");
               fail_count++;
            end else begin
               want = tick_expect_q.pop_front();
               if (rsp_data.membrane_potential !== want.membrane_potential) begin
                  $error("membrane_potential exp %0d got %0d",
                         want.membrane_potential, rsp_data.membrane_potential);
                  fail_count++;
               end
               if (rsp_data.recovery_value !== want.recovery_value) begin
                  $error("recovery_value exp %0d got %0d",
                         want.recovery_value, rsp_data.recovery_value);
                  fail_count++;
               end
               if (rsp_data.spiked !== want.spiked) begin
                  $error("spiked exp %0d got %0d", want.spiked, rsp_data.spiked);
                  fail_count++;
               end
               if (rsp_data.raw_output !== want.raw_output) begin
                  $error("raw_output exp %0d got %0d",
                         want.raw_output, rsp_data.raw_output);
                  fail_count++;
               end
               if (rsp_data.normalized_output !== want.normalized_output) begin
                  $error("normalized_output exp %0d got %0d",
                         want.normalized_output, rsp_data.normalized_output);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no accept on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_tick(longint cur, longint noi);
      izn_pkg::req_type rq;
      rq.synaptic_current = cur[31:0];
      rq.noise_sample     = noi[31:0];
      tick_q.insert(tick_q.size(), rq);
   endtask

   // mostly spike-provoking currents with small noise, some full-range words
   task automatic push_random_tick();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) push_tick(longint'(signed'($urandom)), longint'(signed'($urandom)));
      else if (sel < 25) push_tick(-longint'($urandom_range(40000000)),
                                   longint'($urandom_range(655360)) - 327680);
      else push_tick(longint'($urandom_range(40000000)),
                     longint'($urandom_range(655360)) - 327680);
   endtask

   task automatic wait_drained();
      wait (tick_q.size() == 0 && req_accepts == req_issued && tick_expect_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write, lowered later by the caller
   task automatic write_reg(int idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx[izn_pkg::IDX_W-1:0];
      csr_wdata <= val;
      if (idx < izn_pkg::NUM_REGS) cfg[idx] = longint'(signed'(val));
   endtask

   task automatic write_all(int setting);
      logic [31:0] val;
      for (int i = 0; i < izn_pkg::NUM_REGS; i++) begin
         case (setting)
            0: val = izn_pkg::CFG_RESET[i];
            1: val = 32'h7fffffff;
            2: val = 32'h80000000;
            3: val = $urandom;
            default: val = izn_pkg::CFG_RESET[i] + $urandom_range(131072) - 65536;
         endcase
         write_reg(i, val);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_issued = 0;
      req_accepts = 0;
      fail_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      quiet_cycles = 0;
      for (int i = 0; i < izn_pkg::NUM_REGS; i++) cfg[i] = izn_pkg::CFG_RESET[i];
      mem_pot = izn_pkg::CFG_RESET[izn_pkg::REG_RESET_POT];
      rec_st  = izn_pkg::CFG_RESET[izn_pkg::REG_REC_JUMP];
      foreach (spike_win[n]) spike_win[n] = 1'b0;
      build_alpha_rom();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, strong drive for spike bursts
      push_tick(0, 0);
      push_tick(64'sd2147483647, 0);
      push_tick(-64'sd2147483648, 0);
      push_tick(0, 64'sd2147483647);
      push_tick(0, -64'sd2147483648);
      push_tick(64'sd2147483647, 64'sd2147483647);
      push_tick(-64'sd2147483648, -64'sd2147483648);
      push_tick(-1, -1);
      for (int i = 0; i < 12; i++) push_tick(64'sd200000000, 0);
      wait_drained();

      // out-of-range index writes are dropped, then late reset-potential and recovery-jump changes
      for (int i = izn_pkg::NUM_REGS; i < 16; i++) write_reg(i, 32'h12345678);
      write_reg(izn_pkg::REG_RESET_POT, -32'sd4000000);
      write_reg(izn_pkg::REG_REC_JUMP, 32'sd100000);
      @(negedge clock);
      csr_we <= 1'b0;
      for (int i = 0; i < 5; i++) push_tick(64'sd200000000, 0);

      // random phases over register settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_all(ph == 5 ? 0 : ph);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         for (int i = 0; i < 46; i++) push_random_tick();
         // sender holds off until all results are back
         if (ph == 2) wait_drained();
         for (int i = 0; i < 46; i++) push_random_tick();
      end

      wait (tick_q.size() == 0 && req_accepts == req_issued && tick_expect_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
